// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker of the tracker.
// Depends on nothing; each macro takes a label, clock and a message string, and all but AST_ALWAYS a reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AST_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define AST_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication that is also checked across reset.
`define AST_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/art_pkg.sv =====
// Shared types, codes and sizes of the acknowledgement retransmission tracker.
// Depends on nothing; the interfaces, the engine, the top level and the checker import it.
`default_nettype none

package art_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int SLOT_OUT_W = 4;
  localparam int ID_BYTES   = 4;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [31:0] ID_MASK =
    (ID_BYTES >= 4) ? 32'hFFFF_FFFF : 32'((64'd1 << (8 * ID_BYTES)) - 64'd1);

  localparam logic [1:0] FUNC_SUBMIT = 2'd0;
  localparam logic [1:0] FUNC_ACK    = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = CFG_IDX_W'(1);

  localparam logic [3:0]  RETRY_LIMIT_RST    = 4'd5;
  localparam logic [15:0] RETRY_INTERVAL_RST = 16'd20;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_TX        = 3'd1,
    ACT_EXHAUSTED = 3'd2,
    ACT_FULL      = 3'd3,
    ACT_ACK       = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0]      id;
    logic [7:0]       dest;
    logic [31:0]      last;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [3:0]  retry_limit;
    logic [15:0] resend_gap;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] msg_id;
    logic [7:0]  dest;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    action_t               action;
    logic [SLOT_OUT_W-1:0] slot;
    logic [31:0]           out_id;
    logic [7:0]            out_dest;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } mem_wr_t;

endpackage

`default_nettype wire

// ===== rtl/art_if.sv =====
// Valid/ready channel interfaces of the tracker: request, response and configuration.
// Depends on art_pkg for the field widths.
`default_nettype none

interface art_req_if
  import art_pkg::*;
  ();
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] msg_id;
  logic [7:0]  dest;
  logic [31:0] now_ms;

  modport source (output valid, func, msg_id, dest, now_ms, input ready);
  modport sink   (input valid, func, msg_id, dest, now_ms, output ready);
endinterface

interface art_rsp_if
  import art_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [2:0]            action;
  logic [SLOT_OUT_W-1:0] slot;
  logic [31:0]           out_id;
  logic [7:0]            out_dest;

  modport source (output valid, action, slot, out_id, out_dest, input ready);
  modport sink   (input valid, action, slot, out_id, out_dest, output ready);
endinterface

interface art_cfg_if
  import art_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/art_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module art_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/art_engine.sv =====
// Slot table engine: pending flags, entry RAM, scan sequencer and result forming.
// Depends on art_pkg and art_ram.
`default_nettype none

module art_engine
  import art_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire item_t   item,
  output logic         res_valid,
  input  wire logic    res_ready,
  output result_t      res
);

  state_t            state;
  state_t            state_next;
  item_t             item_q;
  logic [SLOTS-1:0]  pend;
  logic [SLOT_W-1:0] scan_cnt;
  logic              rd_vld;
  logic [SLOT_W-1:0] rd_slot;
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  entry_t            hit_entry;
  logic [ENTRY_W-1:0] rdata;
  entry_t            rd_entry;
  mem_wr_t           mem_wr;
  logic              take;
  logic              free_any;
  logic [SLOT_W-1:0] free_slot;
  logic [CNT_W-1:0]  cnt_new;
  logic              retire;
  logic              claim;
  logic [31:0]       age;

  art_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (mem_wr.en),
    .waddr(mem_wr.addr),
    .wdata(mem_wr.data),
    .raddr(scan_cnt),
    .rdata(rdata)
  );

  assign rd_entry = entry_t'(rdata);
  assign age      = item_q.now_ms - rd_entry.last;

  // Highest-numbered free slot.
  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!pend[i]) begin
        free_any  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  // Ack keeps the first match of the upward scan, tick keeps the last one.
  always_comb begin
    take = 1'b0;
    if (rd_vld && pend[rd_slot]) begin
      if (item_q.func == FUNC_ACK) begin
        take = !hit && (rd_entry.id == item_q.msg_id);
      end else begin
        take = age > {16'd0, cfg.resend_gap};
      end
    end
  end

  assign cnt_new = hit_entry.cnt + CNT_W'(1);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (item.func == FUNC_ACK || item.func == FUNC_TICK) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_cnt == SLOT_W'(SLOTS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: handshake, result and RAM write.
  always_comb begin
    in_ready    = (state == ST_IDLE);
    res_valid   = (state == ST_DONE);
    res         = '{action: ACT_NONE, slot: '0, out_id: '0, out_dest: '0};
    mem_wr      = '0;
    retire      = 1'b0;
    claim       = 1'b0;
    if (state == ST_DONE) begin
      unique case (item_q.func)
        FUNC_SUBMIT: begin
          if (free_any) begin
            claim         = 1'b1;
            res.action    = ACT_TX;
            res.slot      = SLOT_OUT_W'(free_slot);
            res.out_id    = item_q.msg_id;
            res.out_dest  = item_q.dest;
            mem_wr.en     = 1'b1;
            mem_wr.addr   = free_slot;
            mem_wr.data   = '{id: item_q.msg_id, dest: item_q.dest, last: '0, cnt: '0};
          end else begin
            res.action = ACT_FULL;
          end
        end
        FUNC_ACK: begin
          if (hit) begin
            retire       = 1'b1;
            res.action   = ACT_ACK;
            res.slot     = SLOT_OUT_W'(hit_slot);
            res.out_id   = hit_entry.id;
            res.out_dest = hit_entry.dest;
          end
        end
        FUNC_TICK: begin
          if (hit) begin
            res.slot     = SLOT_OUT_W'(hit_slot);
            res.out_id   = hit_entry.id;
            res.out_dest = hit_entry.dest;
            mem_wr.en    = 1'b1;
            mem_wr.addr  = hit_slot;
            mem_wr.data  = '{id: hit_entry.id, dest: hit_entry.dest,
                             last: item_q.now_ms, cnt: cnt_new};
            if (cnt_new > {1'b0, cfg.retry_limit}) begin
              retire     = 1'b1;
              res.action = ACT_EXHAUSTED;
            end else begin
              res.action = ACT_TX;
            end
          end
        end
        default: res.action = ACT_NONE;
      endcase
      if (!res_ready) begin
        mem_wr.en = 1'b0;
        retire    = 1'b0;
        claim     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pend   <= '0;
      rd_vld <= 1'b0;
      hit    <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == ST_SCAN);
      if (in_valid && in_ready) begin
        hit <= 1'b0;
      end else if (take) begin
        hit <= 1'b1;
      end
      if (claim) begin
        pend[free_slot] <= 1'b1;
      end else if (retire) begin
        pend[hit_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q   <= '{func: item.func, msg_id: item.msg_id & ID_MASK, dest: item.dest,
                    now_ms: item.now_ms};
      scan_cnt <= '0;
    end else if (state == ST_SCAN) begin
      scan_cnt <= scan_cnt + SLOT_W'(1);
    end
    rd_slot <= scan_cnt;
    if (take) begin
      hit_slot  <= rd_slot;
      hit_entry <= rd_entry;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ack_retransmit_tracker_unit.sv =====
// A submit or unused code goes from acceptance through DONE into the output register; an ack or a
// tick first scans the entry RAM one slot per cycle in SCAN, then passes through DRAIN and DONE.
// The engine takes a new item only in IDLE, so each item is finished before the next is taken;
// an ack or a tick holds the engine while the scan walks the single read port of the entry RAM.
// Reset (rst, synchronous): all slots free, registers back to limit 5 and interval 20;
// the entry RAM is not cleared, since the entries of free slots are never used.
`default_nettype none

// Top level of the acknowledgement retransmission tracker.
// Depends on art_pkg, the channel interfaces and art_engine.
module ack_retransmit_tracker_unit
  import art_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  art_req_if.sink   req,
  art_rsp_if.source rsp,
  art_cfg_if.sink   cfg
);

  // Configuration registers. Writes must arrive only while the block is idle; the block
  // does not enforce it, and the engine reads them directly without any shadowing.
  cfg_t    cfg_q;
  item_t   item;
  logic    res_valid;
  logic    res_ready;
  result_t res;

  // The output register holds one finished item so the engine can go on to the
  // next request while the response side is stalled.
  logic    out_valid;
  result_t out_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.retry_limit <= RETRY_LIMIT_RST;
      cfg_q.resend_gap  <= RETRY_INTERVAL_RST;
    end else if (cfg.valid) begin
      // Indexes beyond the register list are accepted and dropped.
      priority case (cfg.index)
        CFG_RETRY_LIMIT:    cfg_q.retry_limit <= cfg.data[3:0];
        CFG_RETRY_INTERVAL: cfg_q.resend_gap  <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  assign item = '{func: req.func, msg_id: req.msg_id, dest: req.dest, now_ms: req.now_ms};

  art_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_q),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .item     (item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // The engine may hand over a new item whenever the register is empty or is
  // being emptied in this same cycle.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.action   = out_q.action;
  assign rsp.slot     = out_q.slot;
  assign rsp.out_id   = out_q.out_id;
  assign rsp.out_dest = out_q.out_dest;

endmodule

`default_nettype wire

// ===== rtl/art_checker.sv =====
// Port-level checker for the tracker and the bind that attaches it to the top level.
// Depends on art_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module art_checker
  import art_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [2:0]            action,
  input wire logic [SLOT_OUT_W-1:0] slot,
  input wire logic [31:0]           out_id,
  input wire logic [7:0]            out_dest
);

  `AST_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(action) && $stable(slot) && $stable(out_id) && $stable(out_dest), "stalled response changed")
  `AST_IMPL(a_action_legal, clk, rst, out_valid, action == ACT_NONE || action == ACT_TX || action == ACT_EXHAUSTED || action == ACT_FULL || action == ACT_ACK, "illegal action code")
  `AST_IMPL(a_empty_fields, clk, rst, out_valid && (action == ACT_FULL || action == ACT_NONE), slot == '0 && out_id == '0 && out_dest == '0, "no-slot result carries fields")
  `AST_ALWAYS(a_reset_quiet, clk, $past(rst), !out_valid, "response valid right after reset")

endmodule

bind ack_retransmit_tracker_unit art_checker u_art_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(rsp.valid),
  .out_ready(rsp.ready),
  .action   (rsp.action),
  .slot     (rsp.slot),
  .out_id   (rsp.out_id),
  .out_dest (rsp.out_dest)
);

`default_nettype wire
